// File: src/indent_dedent_tracker_top_macros.svh
// ============================================================================
// Indent/dedent tracker assertion macros
// Shared concurrent assertion shorthands, clocked on aclk and disabled during
// reset.
// ============================================================================
`ifndef INDENT_DEDENT_TRACKER_TOP_MACROS_SVH
`define INDENT_DEDENT_TRACKER_TOP_MACROS_SVH

// Check an expression at every clock edge.
`define IDDT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define IDDT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define IDDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/iddt_pkg.sv
// ============================================================================
// Indent/dedent tracker package
// Field widths, character codes, result kinds, error codes and register
// indexes of the indentation tracker.
// ============================================================================
package iddt_pkg;

    localparam int CODE_POINT_W = 21;
    localparam int STOP_W       = 7;
    localparam int KIND_W       = 2;
    localparam int ERR_W        = 2;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CODE_POINT_W-1:0] CH_SPACE   = 21'd32;
    localparam logic [CODE_POINT_W-1:0] CH_TAB     = 21'd9;
    localparam logic [CODE_POINT_W-1:0] CH_NEWLINE = 21'd10;

    localparam logic [KIND_W-1:0] KIND_INDENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEDENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TABSPACE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOODEEP  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DEDENT   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_STOP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_STOP  = 1'b1;

    localparam logic [STOP_W-1:0] MAIN_STOP_RESET = 7'd8;
    localparam logic [STOP_W-1:0] ALT_STOP_RESET  = 7'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic              last;
    } result_t;

endpackage

// File: src/indent_dedent_tracker_top.sv
// ============================================================================
// Indent/dedent tracker
// Offside-rule indentation tracker: measures leading whitespace of each line
// and emits INDENT, DEDENT or indentation error results.
// ============================================================================
// Usage and timing: one code point is accepted per request on the s_ channel.
// A character that is not at the start of a line, a space or a newline at the
// start of a line, is handled in the idle state. A tab at the start of a line
// runs a single shared restoring remainder unit, one bit per cycle, which
// rounds the main column and then the alternate column to the next tab stop.
// The first other character of a line first fetches the top of the level
// stack, is then judged, then yields each DEDENT result in turn (the stack
// walk reads one level per cycle while the output register is free, from a
// memory with a registered read port), and last any error that follows dedents.
// Every result goes through a one-deep output register; a stalled m_ready
// holds the sequencer. s_ready is high only while the sequencer is idle.
// The level stack needs no clearing pass: level 0 is fixed at zero and every
// deeper level is written by its push before it is ever read.
// Configuration writes (main and alternate tab stop; zero acts as one) take
// effect at the next edge and belong to idle periods only.
`include "indent_dedent_tracker_top_macros.svh"

module indent_dedent_tracker_top #(
    parameter int MAX_LEVELS  = 64,
    parameter int COLUMN_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [iddt_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [iddt_pkg::STOP_W-1:0]        cfg_wr_data,
    // input characters
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [iddt_pkg::CODE_POINT_W-1:0]  s_code_point,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [iddt_pkg::KIND_W-1:0]        m_token_kind,
    output logic [iddt_pkg::ERR_W-1:0]         m_error_code,
    output logic                               m_last
);

    import iddt_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_LEVELS);
    localparam int CNT_W   = $clog2(COLUMN_BITS);
    localparam logic [COLUMN_BITS-1:0] COL_MAX   = '1;
    localparam logic [DEPTH_W-1:0]     DEPTH_TOP = DEPTH_W'(MAX_LEVELS - 1);
    localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(COLUMN_BITS - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_JUDGE = 3'd2;
    localparam logic [2:0] ST_POP   = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [2:0]             state_reg, state_next;
    logic [STOP_W-1:0]      main_stop_reg, alt_stop_reg;
    logic                   at_line_start_reg, at_line_start_next;
    logic [COLUMN_BITS-1:0] main_col_reg, main_col_next;
    logic [COLUMN_BITS-1:0] alt_col_reg, alt_col_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [COLUMN_BITS-1:0] div_shift_reg, div_shift_next;
    logic [STOP_W-1:0]      div_rem_reg, div_rem_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                   div_phase_reg, div_phase_next;
    logic [ERR_W-1:0]       err_code_reg, err_code_next;

    logic                   m_valid_reg;
    logic [KIND_W-1:0]      m_token_kind_reg;
    logic [ERR_W-1:0]       m_error_code_reg;
    logic                   m_last_reg;

    // level stack: {column, alternate column} per level
    logic [2*COLUMN_BITS-1:0] level_mem [MAX_LEVELS];
    logic [2*COLUMN_BITS-1:0] rd_data_reg;
    logic                     mem_we;
    logic [DEPTH_W-1:0]       mem_wr_addr;

    // ------------------------------------------------------------------------
    // Shared remainder unit: one restoring step per cycle
    // ------------------------------------------------------------------------
    logic [STOP_W-1:0]      main_eff, alt_eff, div_size;
    logic [STOP_W:0]        div_trial, div_diff;
    logic                   div_ge;
    logic [STOP_W-1:0]      div_rem_new, div_gap;
    logic [COLUMN_BITS-1:0] div_col, div_round;
    logic [COLUMN_BITS:0]   div_sum;

    // a size of zero acts as one
    assign main_eff = (main_stop_reg == '0) ? STOP_W'(1) : main_stop_reg;
    assign alt_eff  = (alt_stop_reg == '0) ? STOP_W'(1) : alt_stop_reg;
    assign div_size = div_phase_reg ? alt_eff : main_eff;
    assign div_col  = div_phase_reg ? alt_col_reg : main_col_reg;

    assign div_trial   = {div_rem_reg, div_shift_reg[COLUMN_BITS-1]};
    assign div_diff    = div_trial - {1'b0, div_size};
    assign div_ge      = (div_trial >= {1'b0, div_size});
    assign div_rem_new = div_ge ? div_diff[STOP_W-1:0] : div_trial[STOP_W-1:0];

    // next tab stop = column - remainder + size, saturated
    assign div_gap   = div_size - div_rem_new;
    assign div_sum   = {1'b0, div_col} + (COLUMN_BITS+1)'(div_gap);
    assign div_round = div_sum[COLUMN_BITS] ? COL_MAX : div_sum[COLUMN_BITS-1:0];

    // ------------------------------------------------------------------------
    // Top of stack view; level 0 always reads as zero
    // ------------------------------------------------------------------------
    logic [COLUMN_BITS-1:0] top_col, top_alt;
    logic                   out_free;
    logic                   out_load;
    result_t                out_res;

    assign top_col  = (depth_reg == '0) ? '0 : rd_data_reg[2*COLUMN_BITS-1:COLUMN_BITS];
    assign top_alt  = (depth_reg == '0) ? '0 : rd_data_reg[COLUMN_BITS-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign mem_wr_addr = depth_reg + DEPTH_W'(1);

    assign s_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next         = state_reg;
        at_line_start_next = at_line_start_reg;
        main_col_next      = main_col_reg;
        alt_col_next       = alt_col_reg;
        depth_next         = depth_reg;
        div_shift_next     = div_shift_reg;
        div_rem_next       = div_rem_reg;
        div_cnt_next       = div_cnt_reg;
        div_phase_next     = div_phase_reg;
        err_code_next      = err_code_reg;
        mem_we             = 1'b0;
        out_load           = 1'b0;
        out_res            = '{kind: KIND_ERROR, err: ERR_NONE, last: 1'b1};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!at_line_start_reg) begin
                        // inside a line: wait for the newline
                        if (s_code_point == CH_NEWLINE) begin
                            at_line_start_next = 1'b1;
                        end
                    end else if (s_code_point == CH_SPACE) begin
                        if (main_col_reg != COL_MAX) begin
                            main_col_next = main_col_reg + COLUMN_BITS'(1);
                        end
                        if (alt_col_reg != COL_MAX) begin
                            alt_col_next = alt_col_reg + COLUMN_BITS'(1);
                        end
                    end else if (s_code_point == CH_TAB) begin
                        // round the main column first, then the alternate
                        div_shift_next = main_col_reg;
                        div_rem_next   = '0;
                        div_cnt_next   = '0;
                        div_phase_next = 1'b0;
                        state_next     = ST_DIV;
                    end else if (s_code_point == CH_NEWLINE) begin
                        // blank line: drop the counts
                        main_col_next = '0;
                        alt_col_next  = '0;
                    end else begin
                        state_next = ST_JUDGE;
                    end
                end
            end

            ST_DIV: begin
                div_rem_next   = div_rem_new;
                div_shift_next = {div_shift_reg[COLUMN_BITS-2:0], 1'b0};
                div_cnt_next   = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_LAST) begin
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    if (!div_phase_reg) begin
                        main_col_next  = div_round;
                        div_shift_next = alt_col_reg;
                        div_phase_next = 1'b1;
                    end else begin
                        alt_col_next = div_round;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_JUDGE: begin
                if (main_col_reg < top_col) begin
                    // pop one level and look at the new top next cycle
                    depth_next = depth_reg - DEPTH_W'(1);
                    state_next = ST_POP;
                end else if (out_free) begin
                    if (main_col_reg == top_col) begin
                        if (alt_col_reg != top_alt) begin
                            out_load = 1'b1;
                            out_res  = '{kind: KIND_ERROR, err: ERR_TABSPACE, last: 1'b1};
                        end
                    end else if (depth_reg == DEPTH_TOP) begin
                        out_load = 1'b1;
                        out_res  = '{kind: KIND_ERROR, err: ERR_TOODEEP, last: 1'b1};
                    end else if (alt_col_reg <= top_alt) begin
                        out_load = 1'b1;
                        out_res  = '{kind: KIND_ERROR, err: ERR_TABSPACE, last: 1'b1};
                    end else begin
                        mem_we     = 1'b1;
                        depth_next = mem_wr_addr;
                        out_load   = 1'b1;
                        out_res    = '{kind: KIND_INDENT, err: ERR_NONE, last: 1'b1};
                    end
                    at_line_start_next = 1'b0;
                    main_col_next      = '0;
                    alt_col_next       = '0;
                    state_next         = ST_IDLE;
                end
            end

            ST_POP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = '{kind: KIND_DEDENT, err: ERR_NONE, last: 1'b0};
                    if (depth_reg != '0 && main_col_reg < top_col) begin
                        depth_next = depth_reg - DEPTH_W'(1);
                    end else if (main_col_reg != top_col) begin
                        err_code_next = ERR_DEDENT;
                        state_next    = ST_ERR;
                    end else if (alt_col_reg != top_alt) begin
                        err_code_next = ERR_TABSPACE;
                        state_next    = ST_ERR;
                    end else begin
                        out_res.last       = 1'b1;
                        at_line_start_next = 1'b0;
                        main_col_next      = '0;
                        alt_col_next       = '0;
                        state_next         = ST_IDLE;
                    end
                end
            end

            ST_ERR: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_res            = '{kind: KIND_ERROR, err: err_code_reg, last: 1'b1};
                    at_line_start_next = 1'b0;
                    main_col_next      = '0;
                    alt_col_next       = '0;
                    state_next         = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            at_line_start_reg <= 1'b1;
            main_col_reg      <= '0;
            alt_col_reg       <= '0;
            depth_reg         <= '0;
            div_cnt_reg       <= '0;
            div_phase_reg     <= 1'b0;
            main_stop_reg     <= MAIN_STOP_RESET;
            alt_stop_reg      <= ALT_STOP_RESET;
        end else begin
            state_reg         <= state_next;
            at_line_start_reg <= at_line_start_next;
            main_col_reg      <= main_col_next;
            alt_col_reg       <= alt_col_next;
            depth_reg         <= depth_next;
            div_cnt_reg       <= div_cnt_next;
            div_phase_reg     <= div_phase_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_MAIN_STOP: main_stop_reg <= cfg_wr_data;
                    CFG_ALT_STOP:  alt_stop_reg  <= cfg_wr_data;
                    default:       main_stop_reg <= main_stop_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_shift_reg <= div_shift_next;
        div_rem_reg   <= div_rem_next;
        err_code_reg  <= err_code_next;
    end

    // level stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            level_mem[mem_wr_addr] <= {main_col_reg, alt_col_reg};
        end
        rd_data_reg <= level_mem[depth_next];
    end

    // ------------------------------------------------------------------------
    // Output register: hold a result until its request is taken
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_token_kind_reg <= out_res.kind;
            m_error_code_reg <= out_res.err;
            m_last_reg       <= out_res.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_token_kind = m_token_kind_reg;
    assign m_error_code = m_error_code_reg;
    assign m_last       = m_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `IDDT_ASSERT_IMPLIES(a_rem_below_size, state_reg == ST_DIV,
        div_rem_reg < div_size, "remainder not below tab size")
    `IDDT_ASSERT_NEXT(a_indent_push, out_load && out_res.kind == KIND_INDENT,
        depth_reg == $past(depth_reg) + DEPTH_W'(1), "indent without push")
    `IDDT_ASSERT_IMPLIES(a_pop_nonzero, state_next == ST_POP && state_reg == ST_JUDGE,
        depth_reg != '0, "pop from level zero")
    `IDDT_ASSERT_IMPLIES(a_idle_after_last, s_ready && m_valid_reg,
        m_last_reg, "idle with results pending")
    `IDDT_ASSERT_IMPLIES(a_err_code_set, state_reg == ST_ERR,
        err_code_reg == ERR_DEDENT || err_code_reg == ERR_TABSPACE, "bad pending error code")

endmodule
